// ----- design/double_ended_queue_assert.svh -----
// assertion macros used by the double-ended queue datapath
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication
`define DQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("double_ended_queue assertion failed");

// next-cycle implication
`define DQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("double_ended_queue assertion failed");

`endif

// ----- design/dq_pkg.sv -----
// shared constants, opcodes and control types of the double-ended queue
package dq_pkg;

  localparam int unsigned DQ_DEPTH    = 1024;
  localparam int unsigned OPCODE_W    = 3;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned COUNT_OUT_W = 11;

  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_QUERY      = 3'd4;

  typedef struct packed {
    logic accept;
    logic load_read;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_read;
  } dp_status_t;

endpackage

// ----- design/dq_if.sv -----
// item channel interfaces of the double-ended queue
interface dq_in_if;
  logic                                valid;
  logic                                ready;
  logic [dq_pkg::OPCODE_W-1:0]         opcode;
  logic signed [dq_pkg::WORD_W-1:0]    push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink (input valid, input opcode, input push_value, output ready);
endinterface

interface dq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dq_pkg::WORD_W-1:0]    popped_value;
  logic                                pop_ok;
  logic                                push_dropped;
  logic [dq_pkg::COUNT_OUT_W-1:0]      entry_count;
  logic                                is_empty;
  logic signed [dq_pkg::WORD_W-1:0]    front_value;
  logic signed [dq_pkg::WORD_W-1:0]    back_value;

  modport source (output valid, output popped_value, output pop_ok, output push_dropped,
                  output entry_count, output is_empty, output front_value,
                  output back_value, input ready);
  modport sink (input valid, input popped_value, input pop_ok, input push_dropped,
                input entry_count, input is_empty, input front_value,
                input back_value, output ready);
endinterface

// ----- design/dq_ram.sv -----
// generic single-write, single-read ram with registered read data
module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/dq_ctrl.sv -----
// controller sequencing accept, ram read and result load
module dq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  dq_pkg::dp_status_t status,
  output dq_pkg::ctrl_cmd_t  cmd
);
  import dq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cmd.accept    = in_valid && (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_nxt = status.need_read ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        cmd.load_read = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/dq_datapath.sv -----
// ring pointers, count, front and back word cache, ring ram and result register
`include "double_ended_queue_assert.svh"

module dq_datapath #(
  parameter int unsigned DEPTH = dq_pkg::DQ_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dq_pkg::ctrl_cmd_t                 cmd,
  output dq_pkg::dp_status_t                status,
  input  logic [dq_pkg::OPCODE_W-1:0]       opcode,
  input  logic signed [dq_pkg::WORD_W-1:0]  push_value,
  output logic signed [dq_pkg::WORD_W-1:0]  popped_value,
  output logic                              pop_ok,
  output logic                              push_dropped,
  output logic [dq_pkg::COUNT_OUT_W-1:0]    entry_count,
  output logic                              is_empty,
  output logic signed [dq_pkg::WORD_W-1:0]  front_value,
  output logic signed [dq_pkg::WORD_W-1:0]  back_value
);
  import dq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [IW-1:0]             front_idx_r, front_idx_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic signed [WORD_W-1:0]  front_word_r, front_word_nxt;
  logic signed [WORD_W-1:0]  back_word_r, back_word_nxt;
  logic signed [WORD_W-1:0]  popped_r, popped_nxt;
  logic                      pop_ok_r, pop_ok_nxt;
  logic                      dropped_r, dropped_nxt;
  logic                      rd_front_r, rd_front_nxt;

  logic signed [WORD_W-1:0]  out_popped_r;
  logic                      out_pop_ok_r;
  logic                      out_dropped_r;
  logic [COUNT_OUT_W-1:0]    out_count_r;
  logic                      out_empty_r;
  logic signed [WORD_W-1:0]  out_front_r;
  logic signed [WORD_W-1:0]  out_back_r;

  logic                      ram_we;
  logic [IW-1:0]             ram_waddr;
  logic                      ram_re;
  logic [IW-1:0]             ram_raddr;
  logic [WORD_W-1:0]         ram_rdata;

  logic                      full;
  logic                      empty;
  logic [IW-1:0]             front_dec;
  logic [IW-1:0]             front_inc;
  logic [IW-1:0]             back_new;
  logic [IW-1:0]             back_prev;

  // ring position a + b, with a below DEPTH and b at most DEPTH
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign front_dec = (front_idx_r == '0) ? IW'(DEPTH - 1) : front_idx_r - IW'(1);
  assign front_inc = wrap_add(front_idx_r, CW'(1));
  assign back_new  = wrap_add(front_idx_r, count_r);
  assign back_prev = wrap_add(front_idx_r, count_r - CW'(2));

  always_comb begin
    front_idx_nxt  = front_idx_r;
    count_nxt      = count_r;
    front_word_nxt = front_word_r;
    back_word_nxt  = back_word_r;
    popped_nxt     = popped_r;
    pop_ok_nxt     = pop_ok_r;
    dropped_nxt    = dropped_r;
    rd_front_nxt   = rd_front_r;
    ram_we         = 1'b0;
    ram_waddr      = front_dec;
    ram_re         = 1'b0;
    ram_raddr      = front_inc;

    if (cmd.accept) begin
      popped_nxt  = '0;
      pop_ok_nxt  = 1'b0;
      dropped_nxt = 1'b0;
      case (opcode)
        OP_PUSH_FRONT: begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            ram_we         = 1'b1;
            ram_waddr      = front_dec;
            front_idx_nxt  = front_dec;
            count_nxt      = count_r + CW'(1);
            front_word_nxt = push_value;
            if (empty) begin
              back_word_nxt = push_value;
            end
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            ram_we        = 1'b1;
            ram_waddr     = back_new;
            count_nxt     = count_r + CW'(1);
            back_word_nxt = push_value;
            if (empty) begin
              front_word_nxt = push_value;
            end
          end
        end
        OP_POP_FRONT: begin
          if (!empty) begin
            pop_ok_nxt    = 1'b1;
            popped_nxt    = front_word_r;
            front_idx_nxt = front_inc;
            count_nxt     = count_r - CW'(1);
            if (count_r == CW'(1)) begin
              front_word_nxt = '0;
              back_word_nxt  = '0;
            end else begin
              ram_re       = 1'b1;
              ram_raddr    = front_inc;
              rd_front_nxt = 1'b1;
            end
          end
        end
        OP_POP_BACK: begin
          if (!empty) begin
            pop_ok_nxt = 1'b1;
            popped_nxt = back_word_r;
            count_nxt  = count_r - CW'(1);
            if (count_r == CW'(1)) begin
              front_word_nxt = '0;
              back_word_nxt  = '0;
            end else begin
              ram_re       = 1'b1;
              ram_raddr    = back_prev;
              rd_front_nxt = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.load_read) begin
      if (rd_front_r) begin
        front_word_nxt = ram_rdata;
      end else begin
        back_word_nxt = ram_rdata;
      end
    end
  end

  assign status.need_read = ram_re;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_idx_r  <= '0;
      count_r      <= '0;
      front_word_r <= '0;
      back_word_r  <= '0;
    end else begin
      front_idx_r  <= front_idx_nxt;
      count_r      <= count_nxt;
      front_word_r <= front_word_nxt;
      back_word_r  <= back_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    popped_r   <= popped_nxt;
    pop_ok_r   <= pop_ok_nxt;
    dropped_r  <= dropped_nxt;
    rd_front_r <= rd_front_nxt;
    if (cmd.load_out) begin
      out_popped_r  <= popped_r;
      out_pop_ok_r  <= pop_ok_r;
      out_dropped_r <= dropped_r;
      out_count_r   <= COUNT_OUT_W'(count_r);
      out_empty_r   <= empty;
      out_front_r   <= front_word_r;
      out_back_r    <= back_word_r;
    end
  end

  dq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (push_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign popped_value = out_popped_r;
  assign pop_ok       = out_pop_ok_r;
  assign push_dropped = out_dropped_r;
  assign entry_count  = out_count_r;
  assign is_empty     = out_empty_r;
  assign front_value  = out_front_r;
  assign back_value   = out_back_r;

  `DQ_ASSERT_IMPL(a_count_range, 1'b1, count_r <= CW'(DEPTH))
  `DQ_ASSERT_IMPL(a_empty_cache_zero, count_r == '0, front_word_r == '0 && back_word_r == '0)
  `DQ_ASSERT_NEXT(a_push_counts, cmd.accept && ram_we, count_r == $past(count_r) + CW'(1))
  `DQ_ASSERT_IMPL(a_read_only_nonempty, ram_re, count_r > CW'(1))

endmodule

// ----- design/double_ended_queue.sv -----
// the controller sequence is accept, ram read, result load; pushes and queries go from the
// accept to ST_DONE, a pop that leaves words behind first passes ST_READ (one ring ram read
// refills the end cache); ST_DONE loads the result once the output slot is free;
// a new item is taken only in ST_IDLE, yet a waiting result does not block the next accept
// reset clears the state machine, front pointer, count and end cache; the ring
// contents are not cleared and are read only after being written
module double_ended_queue #(
  parameter int unsigned DEPTH = dq_pkg::DQ_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  dq_in_if.sink     in_chan,
  dq_out_if.source  out_chan
);
  import dq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .opcode       (in_chan.opcode),
    .push_value   (in_chan.push_value),
    .popped_value (out_chan.popped_value),
    .pop_ok       (out_chan.pop_ok),
    .push_dropped (out_chan.push_dropped),
    .entry_count  (out_chan.entry_count),
    .is_empty     (out_chan.is_empty),
    .front_value  (out_chan.front_value),
    .back_value   (out_chan.back_value)
  );

endmodule

// ----- tb/sv/tb_double_ended_queue.sv -----
// testbench for the double-ended queue: random ops, a full-ring fill and a deque predictor
module tb_double_ended_queue;
  import dq_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;
  localparam logic [WORD_W-1:0]   WORD_MAX   = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0]   WORD_MIN   = 32'h8000_0000;
  localparam int                  STALL_LIMIT = 4000;
  localparam int                  HOLD_CYCLES = 400;
  localparam int                  HOLD_AFTER  = 500;

  typedef struct packed {
    logic [WORD_W-1:0]      popped_value;
    logic                   pop_ok;
    logic                   push_dropped;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   is_empty;
    logic [WORD_W-1:0]      front_value;
    logic [WORD_W-1:0]      back_value;
  } deque_result_t;

  class deque_tracker;
    logic [WORD_W-1:0] ring [DQ_DEPTH];
    int unsigned       head;
    int unsigned       stored;
    deque_result_t     pending[$];
    int                errors;
    int                results_seen;
    int                pushes;
    int                dropped;
    int                pops_hit;
    int                pops_missed;
    int unsigned       peak;

    function new();
      head = 0;
      stored = 0;
      errors = 0;
      results_seen = 0;
      pushes = 0;
      dropped = 0;
      pops_hit = 0;
      pops_missed = 0;
      peak = 0;
    endfunction

    function void note_op(logic [OPCODE_W-1:0] op, logic [WORD_W-1:0] word);
      deque_result_t r;
      r = '0;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (stored >= DQ_DEPTH) begin
            r.push_dropped = 1'b1;
            dropped++;
          end else begin
            if (op == OP_PUSH_FRONT) begin
              head = (head + DQ_DEPTH - 1) % DQ_DEPTH;
              ring[head] = word;
            end else begin
              ring[(head + stored) % DQ_DEPTH] = word;
            end
            stored++;
            pushes++;
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (stored != 0) begin
            r.pop_ok = 1'b1;
            if (op == OP_POP_FRONT) begin
              r.popped_value = ring[head];
              head = (head + 1) % DQ_DEPTH;
            end else begin
              r.popped_value = ring[(head + stored - 1) % DQ_DEPTH];
            end
            stored--;
            pops_hit++;
          end else begin
            pops_missed++;
          end
        end
        default: ;
      endcase
      if (stored != 0) begin
        r.front_value = ring[head];
        r.back_value  = ring[(head + stored - 1) % DQ_DEPTH];
      end
      r.entry_count = stored[COUNT_OUT_W-1:0];
      r.is_empty    = (stored == 0);
      if (stored > peak) peak = stored;
      pending.insert(pending.size(), r);
    endfunction

    task report(string field, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      errors++;
      if (errors <= 50)
        $display("mismatch at result %0d, %s: got %h want %h", results_seen, field, got, want);
    endtask

    task check_result(deque_result_t got);
      deque_result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        report("no item pending", 0, 0);
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (got.popped_value !== want.popped_value)
        report("popped_value", got.popped_value, want.popped_value);
      if (got.pop_ok !== want.pop_ok) report("pop_ok", got.pop_ok, want.pop_ok);
      if (got.push_dropped !== want.push_dropped)
        report("push_dropped", got.push_dropped, want.push_dropped);
      if (got.entry_count !== want.entry_count)
        report("entry_count", got.entry_count, want.entry_count);
      if (got.is_empty !== want.is_empty) report("is_empty", got.is_empty, want.is_empty);
      if (got.front_value !== want.front_value)
        report("front_value", got.front_value, want.front_value);
      if (got.back_value !== want.back_value)
        report("back_value", got.back_value, want.back_value);
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   in_calm;
  bit   out_calm;
  int   items_sent;

  deque_tracker tracker = new();

  dq_in_if  in_chan ();
  dq_out_if out_chan ();

  double_ended_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 5));
  endfunction

  function automatic logic [WORD_W-1:0] draw_word();
    case ($urandom_range(0, 39))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OPCODE_W-1:0] draw_op(int push_pct, int pop_pct);
    int r;
    r = int'($urandom_range(0, 99));
    if (r < push_pct) return ($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (r < push_pct + pop_pct)
      return ($urandom_range(0, 1) != 0) ? OP_POP_BACK : OP_POP_FRONT;
    case ($urandom_range(0, 5))
      0: return OP_SPARE_5;
      1: return OP_SPARE_6;
      2: return OP_SPARE_7;
      default: return OP_QUERY;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] word);
    int gap;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.opcode     <= op;
    in_chan.push_value <= word;
    do begin
      @(posedge clk);
    end while (in_chan.ready !== 1'b1);
    tracker.note_op(op, word);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic run_mix(input int n, input int push_pct, input int pop_pct);
    repeat (n) send_op(draw_op(push_pct, pop_pct), draw_word());
  endtask

  initial begin : result_sink
    int            gap;
    bit            held;
    deque_result_t got;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      // one long stall so the block backs up into its input
      if (!held && tracker.results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        gap = 0;
      end else begin
        gap = draw_wait(out_calm);
      end
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (out_chan.valid !== 1'b1);
      got.popped_value = out_chan.popped_value;
      got.pop_ok       = out_chan.pop_ok;
      got.push_dropped = out_chan.push_dropped;
      got.entry_count  = out_chan.entry_count;
      got.is_empty     = out_chan.is_empty;
      got.front_value  = out_chan.front_value;
      got.back_value   = out_chan.back_value;
      tracker.check_result(got);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
          (out_chan.valid === 1'b1 && out_chan.ready === 1'b1))
        idle = 0;
      else if (rst_n === 1'b1)
        idle++;
      if (idle >= STALL_LIMIT) begin
        $display("no item moved for %0d cycles, %0d results pending", idle,
                 tracker.pending.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.opcode      = OP_QUERY;
    in_chan.push_value  = '0;
    out_chan.ready      = 1'b0;
    in_calm             = 1'b0;
    out_calm            = 1'b1;
    items_sent          = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty queue, extremes, spare opcodes, both ends
    send_op(OP_QUERY, '0);
    send_op(OP_POP_FRONT, WORD_MAX);
    send_op(OP_POP_BACK, WORD_MIN);
    send_op(OP_PUSH_BACK, WORD_MAX);
    send_op(OP_PUSH_FRONT, WORD_MIN);
    send_op(OP_SPARE_5, '1);
    send_op(OP_SPARE_6, '0);
    send_op(OP_SPARE_7, 32'h5a5a_5a5a);
    send_op(OP_PUSH_BACK, '0);
    send_op(OP_PUSH_FRONT, '1);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_PUSH_FRONT, 32'h1234_5678);
    send_op(OP_POP_BACK, '0);
    send_op(OP_PUSH_BACK, 32'ha5a5_a5a5);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_QUERY, '1);

    // balanced traffic near empty
    run_mix(150, 40, 40);

    // fill the ring, then push into it while full
    while (tracker.stored < DQ_DEPTH) send_op(draw_op(92, 4), draw_word());
    repeat (12) begin
      send_op(($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT, draw_word());
      send_op(draw_op(0, 0), draw_word());
    end

    // drain-heavy traffic
    run_mix(400, 25, 65);

    in_chan.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d items and %0d results: %0d words stored, %0d pushes dropped",
             items_sent, tracker.results_seen, tracker.pushes, tracker.dropped);
    $display("pops: %0d removed a word, %0d found the queue empty; peak occupancy %0d",
             tracker.pops_hit, tracker.pops_missed, tracker.peak);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
